FILE: design/gwm_pkg.sv
// gwm_pkg: shared constants, item kind codes, case folding and the cell control bundle
// for the glob wildcard matcher. No dependencies.

package gwm_pkg;

   // pattern storage depth, one cell per pattern byte
   localparam int MAX_PATTERN = 32;

   // glob metacharacters
   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] ANY_BYTE  = 8'h3F;

   // item kind codes on the request channel
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_PATTERN = 2'd0;
   localparam kind_type KIND_SUBJECT = 2'd1;
   localparam kind_type KIND_END     = 2'd2;

   // broadcast from the top level to every cell for one accepted beat
   typedef struct packed {
      logic       pat_load;     // pattern byte accepted
      logic       pat_first;    // that pattern byte starts a new pattern
      logic       subj_step;    // subject byte accepted
      logic       restart;      // live set goes back to position zero
      logic [7:0] char_folded;  // beat byte with a-z folded to upper case
   } cell_ctrl_type;

   // fold ascii lower case letters to upper case
   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b inside {[8'h61:8'h7A]}) begin
         r = b - 8'h20;
      end
      return r;
   endfunction

endpackage

FILE: design/glob_wildcard_match_core.sv
// glob_wildcard_match_core: case-insensitive glob matcher built as a chain of
// pattern cells with a registered result stage. Depends on gwm_pkg, gwm_cell.
//
// Usage: send pattern bytes on the req channel with req_kind = pattern, the first
// one flagged by req_first_of_pattern. Then send subject bytes (kind subject) and
// close each subject with an end beat (kind end). Only an end beat produces a rsp
// beat: rsp_matched tells whether the whole subject matched the pattern,
// rsp_pattern_too_long whether the pattern ran past MAX_PATTERN bytes (extra bytes
// are dropped and matched is then 0). '?' matches any byte, '*' any run of bytes,
// letters compare case-insensitively. Kind three is ignored.
// Throughput: one beat per cycle of any kind while req_ready is high. Latency:
// the rsp beat is valid in the cycle after its end beat is accepted. The live
// position set sits in the cells; each subject byte moves it one step and closes
// it over stars by a combinational ripple through the cell chain.
// Reset: empty pattern, live set at position zero, no rsp pending; no clearing
// pass is needed. When the receiver stalls, the rsp register holds its beat and
// req_ready drops only while that register is full and rsp_ready is low.

module glob_wildcard_match_core
   import gwm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_char_value,
   input  logic       req_first_of_pattern,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_pattern_too_long
);

   cell_ctrl_type ctrl;
   logic          take;
   logic          end_take;
   logic [MAX_PATTERN:0]   vchain;
   logic [MAX_PATTERN:0]   carry;
   logic [MAX_PATTERN:0]   match;
   logic [MAX_PATTERN-1:0] hit;
   logic          tail_raw_ff, tail_raw_in;
   logic          tail_closed;
   logic          any_hit;
   logic          overflow_ff, overflow_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_matched_ff;
   logic          rsp_too_long_ff;

   // input handshake and beat decode
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign take      = req_valid & req_ready;

   always_comb begin
      ctrl           = '0;
      ctrl.char_folded = fold_case(req_char_value);
      ctrl.pat_first = req_first_of_pattern;
      end_take       = 1'b0;
      case (req_kind)
         KIND_PATTERN: ctrl.pat_load  = take;
         KIND_SUBJECT: ctrl.subj_step = take;
         KIND_END:     end_take       = take;
         default:      ;
      endcase
      ctrl.restart = ctrl.pat_load | end_take;
   end

   // chain of pattern cells
   assign vchain[0] = 1'b1;
   assign carry[0]  = 1'b0;
   assign match[0]  = 1'b0;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      gwm_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .is_head       (i == 0),
         .prev_valid_in (vchain[i]),
         .carry_in      (carry[i]),
         .match_in      (match[i]),
         .valid_out     (vchain[i+1]),
         .carry_out     (carry[i+1]),
         .match_out     (match[i+1]),
         .hit_out       (hit[i])
      );
   end

   // position past the last cell, reached only by a full pattern
   assign tail_closed = tail_raw_ff | carry[MAX_PATTERN];
   assign any_hit     = (|hit) | (tail_closed & vchain[MAX_PATTERN]);

   always_comb begin
      tail_raw_in = tail_raw_ff;
      if (ctrl.restart) begin
         tail_raw_in = 1'b0;
      end else if (ctrl.subj_step) begin
         tail_raw_in = match[MAX_PATTERN];
      end
   end

   // overflow flag: a pattern byte that finds every cell full
   always_comb begin
      overflow_in = overflow_ff;
      if (ctrl.pat_load) begin
         overflow_in = ctrl.pat_first ? 1'b0 : vchain[MAX_PATTERN];
      end
   end

   // result stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (end_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_raw_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tail_raw_ff  <= tail_raw_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_take) begin
         rsp_matched_ff  <= any_hit & ~overflow_ff;
         rsp_too_long_ff <= overflow_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_too_long = rsp_too_long_ff;

endmodule

FILE: design/gwm_cell.sv
// gwm_cell: one pattern position of the matcher chain; holds a pattern byte,
// its valid flag and the raw live bit for that position. Depends on gwm_pkg.

module gwm_cell
   import gwm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          is_head,        // first cell of the chain
   input  logic          prev_valid_in,  // left neighbor holds a pattern byte
   input  logic          carry_in,       // live through a star on the left
   input  logic          match_in,       // left neighbor consumed the subject byte
   output logic          valid_out,
   output logic          carry_out,
   output logic          match_out,
   output logic          hit_out
);

   logic       raw_ff, raw_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       closed;
   logic       is_star;
   logic       byte_hit;
   logic       write_here;

   // live bit after closing over stars to the left
   assign closed   = raw_ff | carry_in;
   assign is_star  = valid_ff & (byte_ff == STAR_BYTE);
   assign byte_hit = (byte_ff == ANY_BYTE) | (byte_ff == ctrl.char_folded);

   assign carry_out = closed & is_star;
   assign match_out = closed & valid_ff & (byte_ff != STAR_BYTE) & byte_hit;
   // this position is the end of the stored pattern
   assign hit_out   = closed & prev_valid_in & ~valid_ff;
   assign valid_out = valid_ff;

   // the next pattern byte lands in the first empty cell
   assign write_here = ctrl.pat_first ? is_head : (prev_valid_in & ~valid_ff);

   // next state of the live bit and the valid flag
   always_comb begin
      raw_in   = raw_ff;
      valid_in = valid_ff;
      if (ctrl.restart) begin
         raw_in = is_head;
      end else if (ctrl.subj_step) begin
         raw_in = match_in | carry_out;
      end
      if (ctrl.pat_load) begin
         valid_in = ctrl.pat_first ? is_head : (valid_ff | write_here);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff   <= is_head;
         valid_ff <= 1'b0;
      end else begin
         raw_ff   <= raw_in;
         valid_ff <= valid_in;
      end
   end

   // pattern byte, stored folded
   always_ff @(posedge clock) begin
      if (ctrl.pat_load && write_here) begin
         byte_ff <= ctrl.char_folded;
      end
   end

endmodule

FILE: design/gwm_checker.sv
// gwm_checker: port-level assertions for glob_wildcard_match_core, bound to the
// top level below. Depends on gwm_pkg.

module gwm_checker
   import gwm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_kind,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_matched,
   input logic       rsp_pattern_too_long
);

   // an overflowed pattern never matches
   a_too_long_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pattern_too_long) |-> !rsp_matched)
      else $error("match reported with overflowed pattern");

   // an accepted end beat gives a rsp beat in the next cycle
   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_END) |=> rsp_valid)
      else $error("end beat without rsp beat");

   // other beats never create a rsp beat
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !(req_valid && req_ready && req_kind == KIND_END)) |=> !rsp_valid)
      else $error("rsp beat without end beat");

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_matched) && $stable(rsp_pattern_too_long)))
      else $error("stalled rsp beat changed");

   // reset leaves no rsp pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind glob_wildcard_match_core gwm_checker u_gwm_checker (.*);
